[rtl/cstp_pkg.sv]
package cstp_pkg;

  localparam int unsigned DW = 32;
  localparam int unsigned DEF_TABLE_ENTRIES = 64;
  localparam int unsigned DEF_STACK_DEPTH = 32;
  localparam logic [15:0] EXCESS_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ENTER = 2'd0,
    OP_EXIT  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic          sub;
  } alu_req_t;

endpackage

[rtl/cstp_alu.sv]
module cstp_alu (
  input  cstp_pkg::alu_req_t      req_i,
  output logic [cstp_pkg::DW-1:0] y_o
);
  import cstp_pkg::*;

  logic [DW-1:0] b_inv;

  assign b_inv = req_i.sub ? ~req_i.b : req_i.b;
  assign y_o   = req_i.a + b_inv + {{(DW-1){1'b0}}, req_i.sub};

endmodule

[rtl/call_stack_time_profiler.sv]
// Enter: a table scan (one record address compared per cycle on the
// record memory port), plus a parent frame update when a parent frame is live.
// Exit: frame and record read-modify-write on the shared adder.
// Read: record read; clear, excess exit, overflow/underflow: no read; one item at a time.
// Reset clears the stack pointer, excess depth count and slot used bits at once.
module call_stack_time_profiler #(
  parameter int unsigned TABLE_ENTRIES = cstp_pkg::DEF_TABLE_ENTRIES,
  parameter int unsigned STACK_DEPTH   = cstp_pkg::DEF_STACK_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] func_addr_i,
  input  logic [31:0] time_start_i,
  input  logic [31:0] time_done_i,
  input  logic [5:0]  slot_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [5:0]  stack_level_o,
  output logic        slot_valid_o,
  output logic [31:0] slot_address_o,
  output logic [31:0] slot_calls_o,
  output logic [31:0] slot_total_o,
  output logic [31:0] slot_self_o,
  output logic [31:0] slot_overhead_o
);
  import cstp_pkg::*;

  localparam int unsigned IW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned FW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic [DW-1:0] addr;
    logic [DW-1:0] calls;
    logic [DW-1:0] total;
    logic [DW-1:0] self_t;
    logic [DW-1:0] ovh;
  } rec_t;

  typedef struct packed {
    logic [IW-1:0] slot;
    logic [DW-1:0] enter;
    logic [DW-1:0] call;
    logic [DW-1:0] child;
    logic [DW-1:0] ovh;
  } frm_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_EHIT, S_EMISS, S_EPAR, S_EPARB, S_EPUSH,
    S_XW, S_XF, S_XR, S_XT, S_XS1, S_XS2, S_XO, S_XWR, S_XPOP, S_XPW,
    S_XP1, S_XP2, S_XP3, S_XP4, S_XP5, S_RW, S_RD, S_FIN
  } state_e;

  state_e state_q;

  rec_t rec_mem [TABLE_ENTRIES];
  frm_t frm_mem [STACK_DEPTH];
  rec_t rec_rd_q;
  frm_t frm_rd_q;

  logic [TABLE_ENTRIES-1:0] used_q;
  logic [STACK_DEPTH-1:0]   untr_q;
  logic [SPW-1:0]           sp_q;
  logic [15:0]              exc_q;

  logic [1:0]    op_q;
  logic [DW-1:0] addr_q, t0_q, t1_q, acc_q;
  logic          rd_ok_q;
  logic [IW:0]   scan_q;
  logic [IW-1:0] cmp_idx_q, free_idx_q, slot_q;
  logic          cmp_vld_q, free_found_q, untrk_q, trk_q;
  logic [FW-1:0] frm_ra_q;
  rec_t          rec_q;
  frm_t          frm_q;
  logic [1:0]    stat_q;

  logic        ov_q;
  logic [1:0]  o_status_q;
  logic [5:0]  o_level_q;
  logic        o_sv_q;
  rec_t        o_rec_q;

  logic [IW-1:0] rec_ra;
  logic          rec_we, frm_we;
  logic [IW-1:0] rec_wa;
  logic [FW-1:0] frm_wa;
  rec_t          rec_wd;
  frm_t          frm_wd;
  alu_req_t      alu_req;
  logic [DW-1:0] alu_y;
  logic          out_free;
  logic          addr_hit;

  cstp_alu u_alu (
    .req_i (alu_req),
    .y_o   (alu_y)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !ov_q || out_ready_i;
  assign rec_ra     = (state_q == S_SCAN) ? scan_q[IW-1:0] : slot_q;
  assign addr_hit   = (rec_rd_q.addr == addr_q);

  always_comb begin
    alu_req = '0;
    case (state_q)
      S_EHIT:  alu_req = '{a: rec_q.calls, b: {{(DW-1){1'b0}}, 1'b1}, sub: 1'b0};
      S_EPAR:  alu_req = '{a: t1_q, b: t0_q, sub: 1'b1};
      S_EPARB: alu_req = '{a: frm_rd_q.ovh, b: acc_q, sub: 1'b0};
      S_XF:    alu_req = '{a: t0_q, b: frm_rd_q.enter, sub: 1'b1};
      S_XT:    alu_req = '{a: rec_rd_q.total, b: acc_q, sub: 1'b0};
      S_XS1:   alu_req = '{a: acc_q, b: frm_q.child, sub: 1'b1};
      S_XS2:   alu_req = '{a: rec_q.self_t, b: acc_q, sub: 1'b0};
      S_XO:    alu_req = '{a: rec_q.ovh, b: frm_q.ovh, sub: 1'b0};
      S_XP1:   alu_req = '{a: t1_q, b: frm_rd_q.call, sub: 1'b1};
      S_XP2:   alu_req = '{a: frm_q.child, b: acc_q, sub: 1'b0};
      S_XP3:   alu_req = '{a: t1_q, b: t0_q, sub: 1'b1};
      S_XP4:   alu_req = '{a: frm_q.ovh, b: acc_q, sub: 1'b0};
      default: alu_req = '0;
    endcase
  end

  always_comb begin
    rec_we = 1'b0;
    rec_wa = slot_q;
    rec_wd = rec_q;
    frm_we = 1'b0;
    frm_wa = frm_ra_q;
    frm_wd = frm_q;
    case (state_q)
      S_EHIT: begin
        rec_we       = 1'b1;
        rec_wd.calls = alu_y;
      end
      S_EMISS: begin
        rec_we = free_found_q;
        rec_wa = free_idx_q;
        rec_wd = '{addr: addr_q, calls: {{(DW-1){1'b0}}, 1'b1}, total: '0,
                   self_t: '0, ovh: '0};
      end
      S_EPARB: begin
        frm_we      = 1'b1;
        frm_wd      = frm_rd_q;
        frm_wd.call = t0_q;
        frm_wd.ovh  = alu_y;
      end
      S_EPUSH: begin
        frm_we = 1'b1;
        frm_wa = sp_q[FW-1:0];
        frm_wd = '{slot: slot_q, enter: t1_q, call: '0, child: '0, ovh: '0};
      end
      S_XWR: rec_we = 1'b1;
      S_XP5: frm_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    if (frm_we) begin
      frm_mem[frm_wa] <= frm_wd;
    end
    rec_rd_q <= rec_mem[rec_ra];
    frm_rd_q <= frm_mem[frm_ra_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      sp_q         <= '0;
      exc_q        <= '0;
      ov_q         <= 1'b0;
      cmp_vld_q    <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i && state_q != S_FIN) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q     <= operation_i;
            addr_q   <= func_addr_i;
            t0_q     <= time_start_i;
            t1_q     <= time_done_i;
            slot_q   <= IW'(32'(slot_index_i));
            rd_ok_q  <= (32'(slot_index_i) < TABLE_ENTRIES);
            frm_ra_q <= FW'(sp_q - SPW'(1));
            stat_q   <= ST_OK;
            untrk_q  <= 1'b0;
            case (op_e'(operation_i))
              OP_ENTER: begin
                if (exc_q != '0 || sp_q >= SPW'(STACK_DEPTH)) begin
                  if (exc_q != EXCESS_MAX) begin
                    exc_q <= exc_q + 16'd1;
                  end
                  stat_q  <= ST_OVERFLOW;
                  state_q <= S_FIN;
                end else begin
                  scan_q       <= '0;
                  cmp_vld_q    <= 1'b0;
                  free_found_q <= 1'b0;
                  state_q      <= S_SCAN;
                end
              end
              OP_EXIT: begin
                if (exc_q != '0) begin
                  exc_q   <= exc_q - 16'd1;
                  state_q <= S_FIN;
                end else if (sp_q == '0) begin
                  stat_q  <= ST_UNDERFLOW;
                  state_q <= S_FIN;
                end else begin
                  state_q <= S_XW;
                end
              end
              OP_READ: state_q <= S_RW;
              OP_CLEAR: begin
                used_q  <= '0;
                untr_q  <= '1;
                state_q <= S_FIN;
              end
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_q < (IW+1)'(TABLE_ENTRIES)) begin
            scan_q <= scan_q + (IW+1)'(1);
          end
          cmp_vld_q <= (scan_q < (IW+1)'(TABLE_ENTRIES));
          cmp_idx_q <= scan_q[IW-1:0];
          if (cmp_vld_q) begin
            if (used_q[cmp_idx_q] && addr_hit) begin
              rec_q   <= rec_rd_q;
              slot_q  <= cmp_idx_q;
              state_q <= S_EHIT;
            end else begin
              if (!used_q[cmp_idx_q] && !free_found_q) begin
                free_found_q <= 1'b1;
                free_idx_q   <= cmp_idx_q;
              end
              if (cmp_idx_q == IW'(TABLE_ENTRIES - 1)) begin
                state_q <= S_EMISS;
              end
            end
          end
        end
        S_EHIT: state_q <= S_EPAR;
        S_EMISS: begin
          if (free_found_q) begin
            used_q[free_idx_q] <= 1'b1;
            slot_q             <= free_idx_q;
          end else begin
            untrk_q <= 1'b1;
            slot_q  <= '0;
            stat_q  <= ST_FULL;
          end
          state_q <= S_EPAR;
        end
        S_EPAR: begin
          acc_q   <= alu_y;
          state_q <= (sp_q != '0) ? S_EPARB : S_EPUSH;
        end
        S_EPARB: state_q <= S_EPUSH;
        S_EPUSH: begin
          untr_q[sp_q[FW-1:0]] <= untrk_q;
          sp_q                 <= sp_q + SPW'(1);
          state_q              <= S_FIN;
        end
        S_XW: state_q <= S_XF;
        S_XF: begin
          frm_q   <= frm_rd_q;
          slot_q  <= frm_rd_q.slot;
          acc_q   <= alu_y;
          trk_q   <= !untr_q[frm_ra_q] && (32'(frm_rd_q.slot) < TABLE_ENTRIES)
                     && used_q[frm_rd_q.slot];
          state_q <= S_XR;
        end
        S_XR: state_q <= trk_q ? S_XT : S_XPOP;
        S_XT: begin
          rec_q   <= '{addr: rec_rd_q.addr, calls: rec_rd_q.calls, total: alu_y,
                       self_t: rec_rd_q.self_t, ovh: rec_rd_q.ovh};
          state_q <= S_XS1;
        end
        S_XS1: begin
          acc_q   <= alu_y;
          state_q <= S_XS2;
        end
        S_XS2: begin
          rec_q.self_t <= alu_y;
          state_q      <= S_XO;
        end
        S_XO: begin
          rec_q.ovh <= alu_y;
          state_q   <= S_XWR;
        end
        S_XWR: state_q <= S_XPOP;
        S_XPOP: begin
          sp_q     <= sp_q - SPW'(1);
          frm_ra_q <= FW'(sp_q - SPW'(2));
          state_q  <= (sp_q > SPW'(1)) ? S_XPW : S_FIN;
        end
        S_XPW: state_q <= S_XP1;
        S_XP1: begin
          frm_q   <= frm_rd_q;
          acc_q   <= alu_y;
          state_q <= S_XP2;
        end
        S_XP2: begin
          frm_q.child <= alu_y;
          state_q     <= S_XP3;
        end
        S_XP3: begin
          acc_q   <= alu_y;
          state_q <= S_XP4;
        end
        S_XP4: begin
          frm_q.ovh <= alu_y;
          state_q   <= S_XP5;
        end
        S_XP5: state_q <= S_FIN;
        S_RW: state_q <= S_RD;
        S_RD: begin
          rec_q   <= rec_rd_q;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            ov_q       <= 1'b1;
            o_status_q <= stat_q;
            o_level_q  <= 6'(sp_q);
            if (op_e'(op_q) == OP_READ && rd_ok_q && used_q[slot_q]) begin
              o_sv_q  <= 1'b1;
              o_rec_q <= rec_q;
            end else begin
              o_sv_q  <= 1'b0;
              o_rec_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = ov_q;
  assign status_o        = o_status_q;
  assign stack_level_o   = o_level_q;
  assign slot_valid_o    = o_sv_q;
  assign slot_address_o  = o_rec_q.addr;
  assign slot_calls_o    = o_rec_q.calls;
  assign slot_total_o    = o_rec_q.total;
  assign slot_self_o     = o_rec_q.self_t;
  assign slot_overhead_o = o_rec_q.ovh;

`ifndef SYNTHESIS
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");
  a_excess_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exc_q != '0 |-> sp_q == SPW'(STACK_DEPTH))
    else $error("excess depth with stack not full");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> scan_q <= (IW+1)'(TABLE_ENTRIES))
    else $error("scan index beyond table");
`endif

endmodule

[tb/call_stack_time_profiler_tb.sv]
module call_stack_time_profiler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cstp_pkg::*;

  localparam int NSLOT = 64;
  localparam int NFRM = 32;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  level;
    logic        valid;
    logic [31:0] addr;
    logic [31:0] calls;
    logic [31:0] total;
    logic [31:0] self_t;
    logic [31:0] ovh;
  } prof_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = '0;
  logic [31:0] func_addr_i = '0;
  logic [31:0] time_start_i = '0;
  logic [31:0] time_done_i = '0;
  logic [5:0]  slot_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [5:0]  stack_level_o;
  logic        slot_valid_o;
  logic [31:0] slot_address_o, slot_calls_o, slot_total_o, slot_self_o, slot_overhead_o;

  call_stack_time_profiler dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic        tbl_used [NSLOT];
  logic [31:0] tbl_addr [NSLOT];
  logic [31:0] tbl_calls [NSLOT];
  logic [31:0] tbl_total [NSLOT];
  logic [31:0] tbl_self [NSLOT];
  logic [31:0] tbl_ovh [NSLOT];
  logic [5:0]  fr_slot [NFRM];
  logic        fr_untracked [NFRM];
  logic [31:0] fr_enter [NFRM];
  logic [31:0] fr_call [NFRM];
  logic [31:0] fr_child [NFRM];
  logic [31:0] fr_ovh [NFRM];
  int          depth;
  int          excess;

  prof_word_t  expected_q[$];
  int          errors = 0;
  int          n_words = 0;
  int          n_results = 0;
  int          n_full = 0, n_over = 0, n_under = 0;
  bit          idle_en = 1'b1;
  int          wdog = 0;
  logic [31:0] tick = 0;
  logic [31:0] addr_pool [16];

  function automatic prof_word_t profile_event(op_e op, logic [31:0] fa, logic [31:0] t0,
                                                logic [31:0] t1, logic [5:0] idx);
    prof_word_t r;
    int s;
    bit hit;
    logic [31:0] span;
    r = '0;
    case (op)
      OP_ENTER: begin
        if (excess != 0 || depth >= NFRM) begin
          if (excess < 65535) excess++;
          r.status = ST_OVERFLOW;
        end else begin
          if (depth > 0) fr_call[depth-1] = t0;
          hit = 0;
          s = 0;
          for (int i = 0; i < NSLOT; i++)
            if (!hit && tbl_used[i] && tbl_addr[i] == fa) begin
              s = i;
              hit = 1;
            end
          if (hit) tbl_calls[s] += 1;
          else begin
            for (int i = 0; i < NSLOT; i++)
              if (!hit && !tbl_used[i]) begin
                s = i;
                hit = 1;
              end
            if (hit) begin
              tbl_used[s] = 1;
              tbl_addr[s] = fa;
              tbl_calls[s] = 1;
              tbl_total[s] = 0;
              tbl_self[s] = 0;
              tbl_ovh[s] = 0;
            end else begin
              s = 0;
              r.status = ST_FULL;
            end
          end
          if (depth > 0) fr_ovh[depth-1] += t1 - t0;
          fr_slot[depth] = s[5:0];
          fr_untracked[depth] = !hit;
          fr_enter[depth] = t1;
          fr_call[depth] = 0;
          fr_child[depth] = 0;
          fr_ovh[depth] = 0;
          depth++;
        end
      end
      OP_EXIT: begin
        if (excess != 0) excess--;
        else if (depth == 0) r.status = ST_UNDERFLOW;
        else begin
          depth--;
          s = fr_slot[depth];
          if (!fr_untracked[depth] && tbl_used[s]) begin
            span = t0 - fr_enter[depth];
            tbl_total[s] += span;
            tbl_self[s] += span - fr_child[depth];
            tbl_ovh[s] += fr_ovh[depth];
          end
          if (depth > 0) begin
            fr_child[depth-1] += t1 - fr_call[depth-1];
            fr_ovh[depth-1] += t1 - t0;
          end
        end
      end
      OP_READ: begin
        if (tbl_used[idx]) begin
          r.valid = 1;
          r.addr = tbl_addr[idx];
          r.calls = tbl_calls[idx];
          r.total = tbl_total[idx];
          r.self_t = tbl_self[idx];
          r.ovh = tbl_ovh[idx];
        end
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) tbl_used[i] = 0;
        for (int i = 0; i < depth; i++) fr_untracked[i] = 1;
      end
    endcase
    r.level = depth[5:0];
    return r;
  endfunction

  task automatic send_word(op_e op, logic [31:0] fa, logic [31:0] t0, logic [31:0] t1,
                           logic [5:0] idx);
    while (idle_en && $urandom_range(99) < 15) @(posedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= op;
    func_addr_i <= fa;
    time_start_i <= t0;
    time_done_i <= t1;
    slot_index_i <= idx;
    expected_q.push_back(profile_event(op, fa, t0, t1, idx));
    if (expected_q[$].status == ST_FULL) n_full++;
    if (expected_q[$].status == ST_OVERFLOW) n_over++;
    if (expected_q[$].status == ST_UNDERFLOW) n_under++;
    n_words++;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_timed(op_e op, logic [31:0] fa);
    logic [31:0] t0;
    t0 = tick + $urandom_range(200);
    tick = t0 + $urandom_range(20);
    send_word(op, fa, t0, tick, 6'($urandom_range(63)));
  endtask

  task automatic read_all();
    for (int i = 0; i < NSLOT; i++) send_word(OP_READ, 0, 0, 0, 6'(i));
  endtask

  always @(posedge clk_i) begin
    if (idle_en) out_ready_i <= ($urandom_range(99) >= 15);
    else out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    prof_word_t got, exp_w;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) wdog = 0;
    else wdog++;
    if (wdog >= WDOG_LIMIT) begin
      $display("%0t watchdog: no progress", $time);
      $display("** call_stack_time_profiler: FAILED **");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {status_o, stack_level_o, slot_valid_o, slot_address_o, slot_calls_o,
             slot_total_o, slot_self_o, slot_overhead_o};
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        errors++;
      end else begin
        exp_w = expected_q.pop_front();
        if (got.status !== exp_w.status) begin
          $display("%0t status exp %0d got %0d", $time, exp_w.status, got.status);
          errors++;
        end
        if (got.level !== exp_w.level) begin
          $display("%0t level exp %0d got %0d", $time, exp_w.level, got.level);
          errors++;
        end
        if (got.valid !== exp_w.valid) begin
          $display("%0t slot_valid exp %0d got %0d", $time, exp_w.valid, got.valid);
          errors++;
        end
        if (got.addr !== exp_w.addr) begin
          $display("%0t address exp %h got %h", $time, exp_w.addr, got.addr);
          errors++;
        end
        if (got.calls !== exp_w.calls) begin
          $display("%0t calls exp %h got %h", $time, exp_w.calls, got.calls);
          errors++;
        end
        if (got.total !== exp_w.total) begin
          $display("%0t total exp %h got %h", $time, exp_w.total, got.total);
          errors++;
        end
        if (got.self_t !== exp_w.self_t) begin
          $display("%0t self exp %h got %h", $time, exp_w.self_t, got.self_t);
          errors++;
        end
        if (got.ovh !== exp_w.ovh) begin
          $display("%0t overhead exp %h got %h", $time, exp_w.ovh, got.ovh);
          errors++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_word(OP_EXIT, 0, 0, 0, 0);
    send_word(OP_ENTER, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 6'h3F);
    send_word(OP_ENTER, 32'h0, 32'h0000_0005, 32'h0000_0010, 0);
    send_word(OP_ENTER, 32'hFFFF_FFFF, 32'h20, 32'h25, 0);
    send_word(OP_EXIT, 0, 32'h30, 32'h38, 0);
    send_word(OP_READ, 0, 0, 0, 0);
    send_word(OP_EXIT, 0, 32'h0, 32'hFFFF_FFFF, 0);
    send_word(OP_EXIT, 32'hFFFF_FFFF, 32'h50, 32'h60, 6'h3F);
    send_word(OP_READ, 0, 0, 0, 0);
    send_word(OP_READ, 0, 0, 0, 1);
    send_word(OP_READ, 0, 0, 0, 6'h3F);
    send_word(OP_ENTER, 32'h1234, 32'h70, 32'h72, 0);
    send_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
    send_word(OP_READ, 0, 0, 0, 0);
    send_word(OP_EXIT, 0, 32'h90, 32'h99, 0);
    send_word(OP_READ, 0, 0, 0, 0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < NSLOT + 2; i++) begin
      send_timed(OP_ENTER, 32'h1000 + i);
      send_timed(OP_EXIT, 0);
    end
    send_timed(OP_ENTER, 32'h9999);
    send_timed(OP_ENTER, 32'h1000);
    send_timed(OP_EXIT, 0);
    send_timed(OP_EXIT, 0);
    read_all();
    send_word(OP_CLEAR, 0, 0, 0, 0);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < NFRM + 4; i++) send_timed(OP_ENTER, addr_pool[i % 16]);
    send_timed(OP_CLEAR, 0);
    for (int i = 0; i < 3; i++) send_timed(OP_ENTER, addr_pool[i]);
    for (int i = 0; i < NFRM + 9; i++) send_timed(OP_EXIT, 0);
    read_all();
  endtask

  task automatic test_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      if (k == n / 3) idle_en = 1'b0;
      if (k == n / 2) idle_en = 1'b1;
      r = $urandom_range(99);
      if (r < 42 && depth < NFRM - 2) send_timed(OP_ENTER, addr_pool[$urandom_range(15)]);
      else if (r < 84) send_timed(OP_EXIT, 0);
      else if (r < 97) send_word(OP_READ, 0, 0, 0, 6'($urandom_range(18)));
      else if (r < 98) send_timed(OP_CLEAR, 0);
      else send_word(op_e'($urandom_range(3)), $urandom, $urandom, $urandom,
                     6'($urandom_range(63)));
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) addr_pool[i] = (i < 2) ? {32{i[0]}} : $urandom;
    depth = 0;
    excess = 0;
    for (int i = 0; i < NSLOT; i++) tbl_used[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_table_full();
    test_overflow();
    test_random(1500);
    read_all();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d words, checked %0d results (%0d full, %0d overflow, %0d underflow).",
             n_words, n_results, n_full, n_over, n_under);
    if (errors == 0 && expected_q.size() == 0) $display("** call_stack_time_profiler: PASSED **");
    else $display("** call_stack_time_profiler: FAILED **");
    $finish;
  end
endmodule
